[sv/csa_pkg.sv]
// Shared types, constants and helpers for the circular shift address generator.
`default_nettype none

package csa_pkg;

  // Number of array dimensions and subscript width.
  localparam int NUM_DIMS = 3;
  localparam int DIM_BITS = 10;

  // A size register holds one more bit than a subscript so that 2**DIM_BITS fits.
  localparam int SIZE_W = DIM_BITS + 1;

  // Linear index width.
  localparam int IDX_W = 30;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [DIM_BITS-1:0] sub_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef size_t [NUM_DIMS-1:0] size_vec_t;
  typedef sub_t  [NUM_DIMS-1:0] sub_vec_t;

  // Effective geometry seen by the datapath: clamped sizes and reduced shifts.
  typedef struct packed {
    size_vec_t size;
    sub_vec_t  shift;
  } csa_cfg_t;

  // Register map, as word indexes.
  localparam reg_idx_t REG_SIZE_DIM0  = reg_idx_t'(0);
  localparam reg_idx_t REG_SIZE_DIM1  = reg_idx_t'(1);
  localparam reg_idx_t REG_SIZE_DIM2  = reg_idx_t'(2);
  localparam reg_idx_t REG_SHIFT_DIM0 = reg_idx_t'(3);
  localparam reg_idx_t REG_SHIFT_DIM1 = reg_idx_t'(4);
  localparam reg_idx_t REG_SHIFT_DIM2 = reg_idx_t'(5);

  // A size of zero acts as one; a size above 2**DIM_BITS saturates there.
  function automatic size_t eff_size(input size_t raw);
    size_t limit;
    size_t res;
    limit = size_t'(1) << DIM_BITS;
    if (raw == '0) begin
      res = size_t'(1);
    end else if (raw > limit) begin
      res = limit;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/csa_shift_reduce.sv]
// Sequencer that reduces each configured shift modulo its effective size.
`default_nettype none

module csa_shift_reduce import csa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  size_vec_t sizes,
  input  sub_vec_t  shifts_raw,
  output sub_vec_t  shifts_mod,
  output logic      busy
);

  localparam int CNT_W = $clog2(DIM_BITS + 2);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIM_BITS + 1);

  logic [CNT_W-1:0] cnt_r;
  sub_vec_t         rem_r;
  sub_vec_t         rem_nxt;
  sub_vec_t         dvd_r;
  sub_vec_t         dvd_nxt;
  size_t            trial;

  // One restoring remainder step per cycle for all dimensions in parallel.
  always_comb begin
    trial   = '0;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int d = 0; d < NUM_DIMS; d++) begin
      trial      = {rem_r[d], dvd_r[d][DIM_BITS-1]};
      dvd_nxt[d] = dvd_r[d] << 1;
      if (trial >= sizes[d]) begin
        rem_nxt[d] = DIM_BITS'(trial - sizes[d]);
      end else begin
        rem_nxt[d] = trial[DIM_BITS-1:0];
      end
    end
  end

  // The first count after a write picks up the freshly written registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rem_r <= '0;
    end else if (load) begin
      cnt_r <= CNT_LOAD;
    end else if (cnt_r == CNT_LOAD) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r == CNT_LOAD) begin
      dvd_r <= shifts_raw;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
    end
  end

  assign shifts_mod = rem_r;
  assign busy       = (cnt_r != '0);

endmodule

`default_nettype wire

[sv/csa_split.sv]
// Pipelined mixed-radix split of a linear index into per-dimension remainders.
`default_nettype none

module csa_split import csa_pkg::*; #(
  parameter int STEP_BITS = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  idx_t      in_index,
  input  size_vec_t sizes,
  output logic      out_vld,
  output sub_vec_t  out_rems
);

  localparam int STAGES = (IDX_W + STEP_BITS - 1) / STEP_BITS;
  localparam int PW     = STAGES * STEP_BITS;
  localparam int NSTG   = NUM_DIMS * STAGES;

  logic [NSTG-1:0] vld_r;
  logic [PW-1:0]   rest_r [NSTG];
  sub_t            rem_r  [NSTG];
  sub_vec_t        subs_r [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    localparam int D = k / STAGES;
    localparam int J = k % STAGES;

    logic          vld_in;
    logic [PW-1:0] rest_in;
    sub_t          rem_in;
    sub_vec_t      subs_in;
    logic [PW-1:0] rest_nxt;
    sub_t          rem_nxt;
    size_t         trial;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rest_in = PW'(in_index);
      assign rem_in  = '0;
      assign subs_in = '0;
    end else if (J == 0) begin : g_dim_start
      // The quotient of the previous dimension is the next dividend.
      assign vld_in  = vld_r[k-1];
      assign rest_in = rest_r[k-1];
      assign rem_in  = '0;
      always_comb begin
        subs_in      = subs_r[k-1];
        subs_in[D-1] = rem_r[k-1];
      end
    end else begin : g_mid
      assign vld_in  = vld_r[k-1];
      assign rest_in = rest_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign subs_in = subs_r[k-1];
    end

    // Restoring division: dividend bits leave at the top, quotient bits enter at the bottom.
    always_comb begin
      trial    = '0;
      rest_nxt = rest_in;
      rem_nxt  = rem_in;
      for (int i = 0; i < STEP_BITS; i++) begin
        trial    = {rem_nxt, rest_nxt[PW-1]};
        rest_nxt = {rest_nxt[PW-2:0], 1'b0};
        if (trial >= sizes[D]) begin
          rem_nxt     = DIM_BITS'(trial - sizes[D]);
          rest_nxt[0] = 1'b1;
        end else begin
          rem_nxt = trial[DIM_BITS-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rest_r[k] <= rest_nxt;
      rem_r[k]  <= rem_nxt;
      subs_r[k] <= subs_in;
    end
  end

  assign out_vld = vld_r[NSTG-1];

  always_comb begin
    out_rems             = subs_r[NSTG-1];
    out_rems[NUM_DIMS-1] = rem_r[NSTG-1];
  end

endmodule

`default_nettype wire

[sv/csa_recombine.sv]
// Applies the circular shifts and rebuilds the linear source index by multiply-add.
`default_nettype none

module csa_recombine import csa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  sub_vec_t in_rems,
  input  csa_cfg_t cfg,
  output logic     out_vld,
  output idx_t     out_index,
  output sub_vec_t out_subs
);

  localparam int NMUL = NUM_DIMS - 1;

  logic     vld_r  [NMUL+1];
  idx_t     acc_r  [NMUL+1];
  sub_vec_t subs_r [NMUL+1];
  sub_vec_t sub_nxt;

  // Move each subscript back by its shift, wrapping within the size.
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (in_rems[d] >= cfg.shift[d]) begin
        sub_nxt[d] = in_rems[d] - cfg.shift[d];
      end else begin
        sub_nxt[d] = DIM_BITS'(SIZE_W'(in_rems[d]) + cfg.size[d] - SIZE_W'(cfg.shift[d]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    subs_r[0] <= sub_nxt;
    acc_r[0]  <= idx_t'(sub_nxt[NUM_DIMS-1]);
  end

  // Horner evaluation from the slowest dimension down, one multiply per stage.
  for (genvar m = 1; m <= NMUL; m++) begin : g_mac
    localparam int D = NUM_DIMS - 1 - m;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[m] <= 1'b0;
      end else begin
        vld_r[m] <= vld_r[m-1];
      end
    end

    always_ff @(posedge clk) begin
      subs_r[m] <= subs_r[m-1];
      acc_r[m]  <= idx_t'(subs_r[m-1][D]) + idx_t'(cfg.size[D]) * acc_r[m-1];
    end
  end

  assign out_vld   = vld_r[NMUL];
  assign out_index = acc_r[NMUL];
  assign out_subs  = subs_r[NMUL];

endmodule

`default_nettype wire

[sv/nd_circular_shift_address.sv]
// Top level of the circular shift address generator for a 3-D column-major array.
// Throughput: one transaction per clock; start is taken whenever busy is low.
// From acceptance to out_strobe a transaction passes the three chained pipelined dividers,
// then the shift stage and the two multiply-add stages.
// After any register write, busy stays high while the shifts are reduced.
// Reset (rst_n low, synchronous) empties the pipeline and sets sizes to 1 and shifts to 0.
`default_nettype none

module nd_circular_shift_address import csa_pkg::*; #(
  parameter int STEP_BITS = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input transactions.
  input  logic                  start,
  output logic                  busy,
  input  logic [IDX_W-1:0]      in_dest_index,
  // Result transactions, one cycle each, no back-pressure.
  output logic                  out_strobe,
  output logic [IDX_W-1:0]      out_source_index,
  output logic [DIM_BITS-1:0]   out_source_sub0,
  output logic [DIM_BITS-1:0]   out_source_sub1,
  output logic [DIM_BITS-1:0]   out_source_sub2
);

  // Stage count of one divider and the resulting end-to-end latency.
  localparam int STAGES = (IDX_W + STEP_BITS - 1) / STEP_BITS;
  localparam int LAT    = NUM_DIMS * STAGES + NUM_DIMS;

  size_vec_t size_r;
  sub_vec_t  shift_r;
  sub_vec_t  shifts_mod;
  csa_cfg_t  cfg;
  reg_idx_t  reg_idx;
  logic      wr_en;
  logic      in_take;
  logic      split_vld;
  sub_vec_t  split_rems;
  sub_vec_t  out_subs;

  // ---------------------------------------------------------------------------
  // Register file. Writes complete in the access phase; pready is tied high.
  // The two low address bits are ignored, and word indexes past the map are
  // ignored on write and read back as zero.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        size_r[d] <= size_t'(1);
      end
      shift_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SIZE_DIM0:  size_r[0]  <= pwdata[SIZE_W-1:0];
        REG_SIZE_DIM1:  size_r[1]  <= pwdata[SIZE_W-1:0];
        REG_SIZE_DIM2:  size_r[2]  <= pwdata[SIZE_W-1:0];
        REG_SHIFT_DIM0: shift_r[0] <= pwdata[DIM_BITS-1:0];
        REG_SHIFT_DIM1: shift_r[1] <= pwdata[DIM_BITS-1:0];
        REG_SHIFT_DIM2: shift_r[2] <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE_DIM0:  prdata = APB_DATA_W'(size_r[0]);
      REG_SIZE_DIM1:  prdata = APB_DATA_W'(size_r[1]);
      REG_SIZE_DIM2:  prdata = APB_DATA_W'(size_r[2]);
      REG_SHIFT_DIM0: prdata = APB_DATA_W'(shift_r[0]);
      REG_SHIFT_DIM1: prdata = APB_DATA_W'(shift_r[1]);
      REG_SHIFT_DIM2: prdata = APB_DATA_W'(shift_r[2]);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective geometry. Sizes are clamped combinationally; the shifts are
  // reduced modulo the clamped size by a small sequencer after each write,
  // and busy holds off new transactions until that finishes.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      cfg.size[d] = eff_size(size_r[d]);
    end
    cfg.shift = shifts_mod;
  end

  csa_shift_reduce u_shift_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (wr_en),
    .sizes      (cfg.size),
    .shifts_raw (shift_r),
    .shifts_mod (shifts_mod),
    .busy       (busy)
  );

  // ---------------------------------------------------------------------------
  // Datapath. The index is split into subscripts by three chained dividers,
  // each taking STEP_BITS quotient bits per stage. Whatever remains after the
  // last division is dropped, so indexes past the array wrap around.
  // ---------------------------------------------------------------------------
  assign in_take = start & ~busy;

  csa_split #(
    .STEP_BITS (STEP_BITS)
  ) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_take),
    .in_index (in_dest_index),
    .sizes    (cfg.size),
    .out_vld  (split_vld),
    .out_rems (split_rems)
  );

  // Shift correction, then source index = s0 + n0*(s1 + n1*s2).
  csa_recombine u_recombine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (split_vld),
    .in_rems   (split_rems),
    .cfg       (cfg),
    .out_vld   (out_strobe),
    .out_index (out_source_index),
    .out_subs  (out_subs)
  );

  assign out_source_sub0 = out_subs[0];
  assign out_source_sub1 = out_subs[1];
  assign out_source_sub2 = out_subs[2];

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // Every accepted transaction produces a result once it has passed the pipeline.
  a_accept_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("accepted transaction did not produce a result on time");

  // No result appears without a matching earlier accepted transaction.
  a_result_has_source : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted transaction");

  // A register write must hold off new transactions while the shifts are reduced.
  a_write_sets_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite) |=> busy)
    else $error("busy not raised after a register write");

  // Reset leaves the block idle with an empty pipeline.
  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("block not idle after reset");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the circular shift address generator.
`timescale 1ns / 1ps

module testbench import csa_pkg::*; ();

  // Unused register slots. Writes there must leave the geometry alone.
  localparam reg_idx_t REG_SPARE_LO = reg_idx_t'(6);
  localparam reg_idx_t REG_SPARE_HI = reg_idx_t'(7);

  // Cycles with no transaction of any kind before the run is declared hung.
  // The longest legal quiet stretch is a register write's busy window plus the
  // pipeline latency.
  localparam int WATCHDOG_LIMIT = 2000;

  // Cycles allowed after the last result so that a stray extra result shows up.
  localparam int TAIL_CYCLES = 30;

  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 130;
  localparam int STEADY_PHASE     = 4;

  // One result transaction, as the block should present it.
  typedef struct packed {
    idx_t src_index;
    sub_t sub0;
    sub_t sub1;
    sub_t sub2;
  } src_addr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  start = 1'b0;
  logic                  busy;
  idx_t                  in_dest_index = '0;

  logic                  out_strobe;
  idx_t                  out_source_index;
  sub_t                  out_source_sub0;
  sub_t                  out_source_sub1;
  sub_t                  out_source_sub2;

  nd_circular_shift_address dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_dest_index    (in_dest_index),
    .out_strobe       (out_strobe),
    .out_source_index (out_source_index),
    .out_source_sub0  (out_source_sub0),
    .out_source_sub1  (out_source_sub1),
    .out_source_sub2  (out_source_sub2)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the geometry registers, holding the raw written values.
  // Reset leaves every size at one and every shift at zero.
  size_t size_cfg  [NUM_DIMS] = '{default: size_t'(1)};
  sub_t  shift_cfg [NUM_DIMS] = '{default: sub_t'(0)};

  // Destination indexes waiting to be sent, and source addresses waiting to come out.
  idx_t      dest_index_q [$];
  src_addr_t src_addr_q [$];

  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;

  // When set, the driver offers a new transaction on every cycle it can.
  bit steady_feed = 1'b0;

  // Length of one dimension as the datapath sees it: a zero size behaves as a
  // single element and anything past 2**DIM_BITS is clamped there.
  function automatic longint unsigned dim_len(size_t raw);
    longint unsigned len;
    len = raw;
    if (len == 0) begin
      len = 1;
    end
    if (len > (longint'(1) << DIM_BITS)) begin
      len = longint'(1) << DIM_BITS;
    end
    return len;
  endfunction

  // Split the destination index into subscripts, fastest dimension first, move
  // each subscript back by its shift and rebuild the linear source index. Any
  // part of the index left over after the last division is simply dropped,
  // which is what makes indexes past the end of the array wrap around.
  function automatic src_addr_t shifted_source(idx_t dest);
    longint unsigned rest;
    longint unsigned n;
    longint unsigned sh;
    longint unsigned stride;
    longint unsigned lin;
    longint unsigned sub [NUM_DIMS];
    src_addr_t res;
    int d;
    rest = dest;
    lin = 0;
    stride = 1;
    for (d = 0; d < NUM_DIMS; d++) begin
      n = dim_len(size_cfg[d]);
      sh = shift_cfg[d] % n;
      sub[d] = (rest % n + n - sh) % n;
      rest = rest / n;
      lin += sub[d] * stride;
      stride *= n;
    end
    res.src_index = idx_t'(lin);
    res.sub0 = sub_t'(sub[0]);
    res.sub1 = sub_t'(sub[1]);
    res.sub2 = sub_t'(sub[2]);
    return res;
  endfunction

  // Number of elements in the whole array under the current geometry.
  function automatic longint unsigned array_elems();
    longint unsigned total;
    int d;
    total = 1;
    for (d = 0; d < NUM_DIMS; d++) begin
      total *= dim_len(size_cfg[d]);
    end
    return total;
  endfunction

  // Random destination index. Most land inside the array, some anywhere in
  // the 30-bit range, and the rest right around the end of the array.
  function automatic idx_t pick_dest_index();
    longint unsigned total;
    longint unsigned v;
    int unsigned r;
    total = array_elems();
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v = $urandom_range(0, int'(total - 1));
    end else if (r < 85) begin
      v = $urandom;
    end else begin
      v = total - 1 + $urandom_range(0, 2);
    end
    return idx_t'(v);
  endfunction

  // Queue one destination index for the driver.
  task automatic send_dest(idx_t dest);
    dest_index_q.push_back(dest);
    n_queued++;
  endtask

  // Wait until every queued transaction has been taken and every expected
  // result has come back. Counting on both sides avoids the window in which
  // the driver has just popped an item but not yet raised start.
  task automatic drain();
    while (n_taken != n_queued || src_addr_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Register write: a setup cycle, then an access cycle that completes at the
  // edge where pready is seen high. The shadow copy changes at that same edge.
  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= REG_SIZE_DIM2) begin
      size_cfg[idx - REG_SIZE_DIM0] = value[SIZE_W-1:0];
    end else if (idx >= REG_SHIFT_DIM0 && idx <= REG_SHIFT_DIM2) begin
      shift_cfg[idx - REG_SHIFT_DIM0] = value[DIM_BITS-1:0];
    end
  endtask

  // Random geometry for one phase. Small sizes dominate so that shifts and
  // wraps happen often; some sizes span the full 11-bit register, which also
  // covers the zero and above-limit cases. Now and then the unused bits of the
  // write data are filled with junk, and a spare register is written.
  task automatic random_geometry();
    logic [APB_DATA_W-1:0] value;
    longint unsigned len;
    int unsigned r;
    int d;
    for (d = 0; d < NUM_DIMS; d++) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        value = $urandom_range(1, 8);
      end else if (r < 8) begin
        value = $urandom_range(1, 1024);
      end else begin
        value = $urandom_range(0, 2047);
      end
      if ($urandom_range(0, 3) == 0) begin
        value |= $urandom << SIZE_W;
      end
      write_reg(reg_idx_t'(REG_SIZE_DIM0 + d), value);
    end
    for (d = 0; d < NUM_DIMS; d++) begin
      len = dim_len(size_cfg[d]);
      if ($urandom_range(0, 1) == 0) begin
        value = $urandom_range(0, 1023);
      end else begin
        value = $urandom_range(0, (len + 2 > 1023) ? 1023 : int'(len + 2));
      end
      if ($urandom_range(0, 3) == 0) begin
        value |= $urandom << DIM_BITS;
      end
      write_reg(reg_idx_t'(REG_SHIFT_DIM0 + d), value);
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    end
  endtask

  // Driver. A transaction is taken at an edge where start is high and busy is
  // low; the expected source address is worked out right then, against the
  // geometry in force. Start is lowered or reloaded only once the current
  // transaction has gone, so start never drops and rises in one step.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        src_addr_q.push_back(shifted_source(in_dest_index));
        n_taken++;
      end
      if (!start || !busy) begin
        if (dest_index_q.size() != 0 && (steady_feed || $urandom_range(0, 99) >= 12)) begin
          start <= 1'b1;
          in_dest_index <= dest_index_q.pop_front();
        end else begin
          // Idle cycle: the index lines carry noise that must be ignored.
          start <= 1'b0;
          in_dest_index <= idx_t'($urandom);
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned exp_val, longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      failures++;
    end
  endtask

  // Monitor. The block cannot be held off, so every strobe is a result
  // transaction that must match the oldest expectation.
  always @(posedge clk) begin
    src_addr_t exp_addr;
    if (rst_n && out_strobe) begin
      if (src_addr_q.size() == 0) begin
        $error("result transaction with no transaction outstanding: source_index %0d",
               out_source_index);
        failures++;
      end else begin
        exp_addr = src_addr_q.pop_front();
        check_field("source_index", exp_addr.src_index, out_source_index);
        check_field("source_sub0", exp_addr.sub0, out_source_sub0);
        check_field("source_sub1", exp_addr.sub1, out_source_sub1);
        check_field("source_sub2", exp_addr.sub2, out_source_sub2);
      end
    end
  end

  // Watchdog. Any input, result or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry is a single element, so every index maps to zero.
    send_dest(idx_t'(0));
    send_dest(idx_t'(1));
    send_dest('1);
    drain();

    // Largest array: 1024 per dimension, the third one written past the limit
    // so that it saturates. Largest shift on the first dimension.
    write_reg(REG_SIZE_DIM0, 32'd1024);
    write_reg(REG_SIZE_DIM1, 32'd1024);
    write_reg(REG_SIZE_DIM2, 32'd2047);
    write_reg(REG_SHIFT_DIM0, 32'd1023);
    write_reg(REG_SHIFT_DIM1, 32'd0);
    write_reg(REG_SHIFT_DIM2, 32'd512);
    send_dest(idx_t'(0));
    send_dest('1);
    send_dest(idx_t'(1023));
    send_dest(idx_t'(1024));
    send_dest(idx_t'(20'hFFFFF));
    send_dest(idx_t'(1 << 20));
    drain();

    // A zero size acts as one, shifts at or past their size wrap, and indexes
    // past the 35-element array fold back. Spare registers must be ignored.
    write_reg(REG_SIZE_DIM0, 32'd0);
    write_reg(REG_SIZE_DIM1, 32'd7);
    write_reg(REG_SIZE_DIM2, 32'd5);
    write_reg(REG_SHIFT_DIM0, 32'd1023);
    write_reg(REG_SHIFT_DIM1, 32'd9);
    write_reg(REG_SHIFT_DIM2, 32'd1023);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    send_dest(idx_t'(0));
    send_dest(idx_t'(34));
    send_dest(idx_t'(35));
    send_dest(idx_t'(36));
    send_dest('1);
    drain();

    // Junk above the register fields must not reach the geometry.
    write_reg(REG_SIZE_DIM0, 32'hFFFF_F803);
    write_reg(REG_SIZE_DIM1, 32'h8000_0001);
    write_reg(REG_SIZE_DIM2, 32'h0000_0400);
    write_reg(REG_SHIFT_DIM0, 32'hFFFF_FC02);
    write_reg(REG_SHIFT_DIM1, 32'hAAAA_AC00);
    write_reg(REG_SHIFT_DIM2, 32'h0001_0401);
    send_dest(idx_t'(5));
    send_dest(idx_t'(3071));
    send_dest(idx_t'(3072));
    send_dest(idx_t'(30'h2AAA_AAAA));
    drain();

    // Random part: a fresh geometry per phase, one phase fed without any gaps.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_geometry();
      steady_feed = (phase == STEADY_PHASE);
      repeat (ITEMS_PER_PHASE) send_dest(pick_dest_index());
      drain();
    end
    steady_feed = 1'b0;

    // Give a stray extra result time to surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (src_addr_q.size() != 0) begin
      $error("%0d result transactions never arrived", src_addr_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
